/* rtl/lhbp_pkg.sv */
// Types and constants shared by the local history branch predictor.
`timescale 1ns / 1ps

package lhbp_pkg;

    localparam int XLEN      = 32;
    localparam int TAG_SHIFT = 11;
    localparam int TAG_W     = XLEN - TAG_SHIFT;
    localparam int CNT_W     = 2;

    localparam logic             OP_PREDICT = 1'b0;
    localparam logic             OP_UPDATE  = 1'b1;
    localparam logic [CNT_W-1:0] CNT_TAKEN  = 2'd2;
    localparam logic [CNT_W-1:0] CNT_MAX    = 2'd3;
    localparam logic [CNT_W-1:0] CNT_MIN    = 2'd0;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic [XLEN-1:0]  target;
    } t_btb_entry;

endpackage

/* rtl/local_history_branch_predictor.sv */
// Two-level local branch predictor with a direct-mapped branch target buffer.
`timescale 1ns / 1ps

// Each transaction is either a predict (op = 0) or an update (op = 1) and returns
// exactly one result transaction, in order. The block is a three-stage pipeline:
// stage 1 registers the BTB and local history table reads, stage 2 the pattern
// counter read picked by that history, and the third stage is the result
// register, which drives o_out_valid. Once the clearing pass is done, a new
// transaction enters every cycle while the result side is not stalled; a stall
// on the result side holds the whole pipeline. Writes from updates still in
// flight are forwarded to younger transactions, so back-to-back updates to the
// same branch or the same counter behave exactly as if done one at a time. After
// reset the block runs a clearing pass over max(BTB_ENTRIES, HISTORY_ENTRIES,
// PATTERN_ENTRIES) indexes (1024 with the default sizes), one entry of each table
// per cycle up to its depth, and holds o_in_stall high until it is done. All
// table sizes must be powers of two. The statistics counters saturate at 2^32-1.
module local_history_branch_predictor #(
    parameter int BTB_ENTRIES     = 512,
    parameter int HISTORY_ENTRIES = 1024,
    parameter int HISTORY_BITS    = 10,
    parameter int PATTERN_ENTRIES = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_op,
    input  logic [lhbp_pkg::XLEN-1:0] i_pc,
    input  logic [lhbp_pkg::XLEN-1:0] i_actual_next_pc,
    input  logic [lhbp_pkg::XLEN-1:0] i_sequential_next_pc,
    input  logic [lhbp_pkg::XLEN-1:0] i_predicted_next_pc,

    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_btb_hit,
    output logic [lhbp_pkg::XLEN-1:0] o_target,
    output logic                     o_taken,
    output logic                     o_mispredicted,
    output logic [lhbp_pkg::XLEN-1:0] o_prediction_count,
    output logic [lhbp_pkg::XLEN-1:0] o_mispredict_count,
    output logic [lhbp_pkg::XLEN-1:0] o_btb_miss_count
);
    import lhbp_pkg::*;

    localparam int BTB_IW  = $clog2(BTB_ENTRIES);
    localparam int HIST_IW = $clog2(HISTORY_ENTRIES);
    localparam int PAT_IW  = $clog2(PATTERN_ENTRIES);
    localparam int CLR_MAX_BH = (BTB_ENTRIES > HISTORY_ENTRIES) ? BTB_ENTRIES : HISTORY_ENTRIES;
    localparam int CLR_DEPTH  = (CLR_MAX_BH > PATTERN_ENTRIES) ? CLR_MAX_BH : PATTERN_ENTRIES;
    localparam int CLR_IW     = $clog2(CLR_DEPTH);

    // ------------------------------------------------------------------
    // Flow control: the whole pipeline moves together on advance.
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic advance;
    logic in_accept;
    logic r_clr_busy;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_clr_busy || !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Clearing pass after reset: zero one entry of each table per cycle up to its depth.
    // ------------------------------------------------------------------
    logic [CLR_IW-1:0] r_clr_idx;
    logic              clr_btb;
    logic              clr_hist;
    logic              clr_pat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + CLR_IW'(1);
            if (r_clr_idx == CLR_IW'(CLR_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Smaller tables finish early; skip indexes past their depth.
    assign clr_btb  = r_clr_busy && ({1'b0, r_clr_idx} < (CLR_IW + 1)'(BTB_ENTRIES));
    assign clr_hist = r_clr_busy && ({1'b0, r_clr_idx} < (CLR_IW + 1)'(HISTORY_ENTRIES));
    assign clr_pat  = r_clr_busy && ({1'b0, r_clr_idx} < (CLR_IW + 1)'(PATTERN_ENTRIES));

    // ------------------------------------------------------------------
    // Stage 1: transaction register plus BTB and history read data.
    // ------------------------------------------------------------------
    logic            r_s1_valid;
    logic            r_s1_op;
    logic [XLEN-1:0] r_s1_pc;
    logic [XLEN-1:0] r_s1_anpc;
    logic [XLEN-1:0] r_s1_snpc;
    logic [XLEN-1:0] r_s1_pnpc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_op   <= i_op;
            r_s1_pc   <= i_pc;
            r_s1_anpc <= i_actual_next_pc;
            r_s1_snpc <= i_sequential_next_pc;
            r_s1_pnpc <= i_predicted_next_pc;
        end
    end

    logic [BTB_IW-1:0]  in_bi;
    logic [HIST_IW-1:0] in_li;

    assign in_bi = i_pc[2 +: BTB_IW];
    assign in_li = i_pc[2 +: HIST_IW];

    // Branch target buffer memory.
    t_btb_entry        r_btb_mem [BTB_ENTRIES];
    t_btb_entry        r_btb_rd;
    logic              btb_we;
    logic [BTB_IW-1:0] btb_wa;
    t_btb_entry        btb_wd;

    always_ff @(posedge i_clk) begin
        if (btb_we) begin
            r_btb_mem[btb_wa] <= btb_wd;
        end
        if (advance) begin
            r_btb_rd <= r_btb_mem[in_bi];
        end
    end

    // Local history memory.
    logic [HISTORY_BITS-1:0] r_hist_mem [HISTORY_ENTRIES];
    logic [HISTORY_BITS-1:0] r_hist_rd;
    logic                    hist_we;
    logic [HIST_IW-1:0]      hist_wa;
    logic [HISTORY_BITS-1:0] hist_wd;

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[hist_wa] <= hist_wd;
        end
        if (advance) begin
            r_hist_rd <= r_hist_mem[in_li];
        end
    end

    // Last writes done at the most recent advance; a transaction that read the
    // table on that same edge saw the old contents and picks these up instead.
    logic                    r_bw_valid;
    logic [BTB_IW-1:0]       r_bw_idx;
    logic [TAG_W-1:0]        r_bw_tag;
    logic [XLEN-1:0]         r_bw_target;
    logic                    r_hw_valid;
    logic [HIST_IW-1:0]      r_hw_idx;
    logic [HISTORY_BITS-1:0] r_hw_data;

    logic [BTB_IW-1:0]       s1_bi;
    logic [HIST_IW-1:0]      s1_li;
    logic [TAG_W-1:0]        s1_tag;
    t_btb_entry              s1_entry;
    logic [HISTORY_BITS-1:0] s1_hist;
    logic                    s1_hit;
    logic                    s1_br_taken;
    logic                    s1_mis;
    logic                    s1_upd;
    logic [PAT_IW-1:0]       s1_pi;

    always_comb begin
        s1_bi  = r_s1_pc[2 +: BTB_IW];
        s1_li  = r_s1_pc[2 +: HIST_IW];
        s1_tag = r_s1_pc[XLEN-1:TAG_SHIFT];

        if (r_bw_valid && (r_bw_idx == s1_bi)) begin
            s1_entry.valid  = 1'b1;
            s1_entry.tag    = r_bw_tag;
            s1_entry.target = r_bw_target;
        end else begin
            s1_entry = r_btb_rd;
        end

        if (r_hw_valid && (r_hw_idx == s1_li)) begin
            s1_hist = r_hw_data;
        end else begin
            s1_hist = r_hist_rd;
        end

        s1_hit      = s1_entry.valid && (s1_entry.tag == s1_tag);
        s1_br_taken = (r_s1_anpc != r_s1_snpc);
        s1_mis      = (r_s1_anpc != r_s1_pnpc);
        s1_upd      = r_s1_valid && (r_s1_op == OP_UPDATE);
        s1_pi       = PAT_IW'(s1_hist);
    end

    // Update writes: fill the BTB on a taken branch, shift the outcome into
    // the history. The clearing pass owns the write ports while it runs.
    always_comb begin
        if (r_clr_busy) begin
            btb_we  = clr_btb;
            btb_wa  = r_clr_idx[BTB_IW-1:0];
            btb_wd  = '0;
            hist_we = clr_hist;
            hist_wa = r_clr_idx[HIST_IW-1:0];
            hist_wd = '0;
        end else begin
            btb_we        = advance && s1_upd && s1_br_taken;
            btb_wa        = s1_bi;
            btb_wd.valid  = 1'b1;
            btb_wd.tag    = s1_tag;
            btb_wd.target = r_s1_anpc;
            hist_we       = advance && s1_upd;
            hist_wa       = s1_li;
            hist_wd       = HISTORY_BITS'({s1_hist, s1_br_taken});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw_valid <= 1'b0;
            r_hw_valid <= 1'b0;
        end else if (advance) begin
            r_bw_valid <= s1_upd && s1_br_taken;
            r_hw_valid <= s1_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_bw_idx    <= s1_bi;
            r_bw_tag    <= s1_tag;
            r_bw_target <= r_s1_anpc;
            r_hw_idx    <= s1_li;
            r_hw_data   <= hist_wd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: pattern counter read data, counter training, totals.
    // ------------------------------------------------------------------
    logic              r_s2_valid;
    logic              r_s2_op;
    logic              r_s2_hit;
    logic [XLEN-1:0]   r_s2_target;
    logic              r_s2_br_taken;
    logic              r_s2_mis;
    logic              r_s2_btb_miss;
    logic [PAT_IW-1:0] r_s2_pi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_op       <= r_s1_op;
            r_s2_hit      <= s1_hit;
            r_s2_target   <= s1_hit ? s1_entry.target : '0;
            r_s2_br_taken <= s1_br_taken;
            r_s2_mis      <= s1_mis;
            r_s2_btb_miss <= s1_br_taken && !s1_hit;
            r_s2_pi       <= s1_pi;
        end
    end

    // Pattern counter memory.
    logic [CNT_W-1:0]  r_pat_mem [PATTERN_ENTRIES];
    logic [CNT_W-1:0]  r_pat_rd;
    logic              pat_we;
    logic [PAT_IW-1:0] pat_wa;
    logic [CNT_W-1:0]  pat_wd;

    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            r_pat_mem[pat_wa] <= pat_wd;
        end
        if (advance) begin
            r_pat_rd <= r_pat_mem[s1_pi];
        end
    end

    logic              r_pw_valid;
    logic [PAT_IW-1:0] r_pw_idx;
    logic [CNT_W-1:0]  r_pw_data;

    logic             s2_upd;
    logic [CNT_W-1:0] s2_cnt;
    logic [CNT_W-1:0] n_cnt;

    logic [XLEN-1:0] r_update_total;
    logic [XLEN-1:0] r_mispredict_total;
    logic [XLEN-1:0] r_btb_miss_total;
    logic [XLEN-1:0] n_update_total;
    logic [XLEN-1:0] n_mispredict_total;
    logic [XLEN-1:0] n_btb_miss_total;

    always_comb begin
        s2_upd = r_s2_valid && (r_s2_op == OP_UPDATE);

        if (r_pw_valid && (r_pw_idx == r_s2_pi)) begin
            s2_cnt = r_pw_data;
        end else begin
            s2_cnt = r_pat_rd;
        end

        // Saturating two-bit counter training.
        n_cnt = s2_cnt;
        if (r_s2_br_taken) begin
            if (s2_cnt != CNT_MAX) begin
                n_cnt = s2_cnt + CNT_W'(1);
            end
        end else begin
            if (s2_cnt != CNT_MIN) begin
                n_cnt = s2_cnt - CNT_W'(1);
            end
        end

        n_update_total     = r_update_total;
        n_mispredict_total = r_mispredict_total;
        n_btb_miss_total   = r_btb_miss_total;
        if (s2_upd) begin
            if (r_update_total != '1) begin
                n_update_total = r_update_total + XLEN'(1);
            end
            if (r_s2_mis && (r_mispredict_total != '1)) begin
                n_mispredict_total = r_mispredict_total + XLEN'(1);
            end
            if (r_s2_btb_miss && (r_btb_miss_total != '1)) begin
                n_btb_miss_total = r_btb_miss_total + XLEN'(1);
            end
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            pat_we = clr_pat;
            pat_wa = r_clr_idx[PAT_IW-1:0];
            pat_wd = '0;
        end else begin
            pat_we = advance && s2_upd;
            pat_wa = r_s2_pi;
            pat_wd = n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw_valid         <= 1'b0;
            r_update_total     <= '0;
            r_mispredict_total <= '0;
            r_btb_miss_total   <= '0;
        end else if (advance) begin
            r_pw_valid         <= s2_upd;
            r_update_total     <= n_update_total;
            r_mispredict_total <= n_mispredict_total;
            r_btb_miss_total   <= n_btb_miss_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pw_idx  <= r_s2_pi;
            r_pw_data <= n_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Result register: hold while the consumer stalls.
    // ------------------------------------------------------------------
    logic            r_out_hit;
    logic [XLEN-1:0] r_out_target;
    logic            r_out_taken;
    logic            r_out_mis;
    logic [XLEN-1:0] r_out_update_total;
    logic [XLEN-1:0] r_out_mispredict_total;
    logic [XLEN-1:0] r_out_btb_miss_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (r_s2_op == OP_PREDICT) begin
                r_out_hit    <= r_s2_hit;
                r_out_target <= r_s2_target;
                r_out_taken  <= (s2_cnt >= CNT_TAKEN);
                r_out_mis    <= 1'b0;
            end else begin
                r_out_hit    <= 1'b0;
                r_out_target <= '0;
                r_out_taken  <= 1'b0;
                r_out_mis    <= r_s2_mis;
            end
            r_out_update_total     <= n_update_total;
            r_out_mispredict_total <= n_mispredict_total;
            r_out_btb_miss_total   <= n_btb_miss_total;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_btb_hit          = r_out_hit;
    assign o_target           = r_out_target;
    assign o_taken            = r_out_taken;
    assign o_mispredicted     = r_out_mis;
    assign o_prediction_count = r_out_update_total;
    assign o_mispredict_count = r_out_mispredict_total;
    assign o_btb_miss_count   = r_out_btb_miss_total;

endmodule

/* tb/lhbp_checker.sv */
// Scoreboard that mirrors the branch predictor state and checks every result transaction.
`timescale 1ns / 1ps

module lhbp_checker #(
    parameter int BTB_ENTRIES     = 512,
    parameter int HISTORY_ENTRIES = 1024,
    parameter int HISTORY_BITS    = 10,
    parameter int PATTERN_ENTRIES = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_op,
    input  logic [lhbp_pkg::XLEN-1:0] i_pc,
    input  logic [lhbp_pkg::XLEN-1:0] i_actual_next_pc,
    input  logic [lhbp_pkg::XLEN-1:0] i_sequential_next_pc,
    input  logic [lhbp_pkg::XLEN-1:0] i_predicted_next_pc,

    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic                      i_btb_hit,
    input  logic [lhbp_pkg::XLEN-1:0] i_target,
    input  logic                      i_taken,
    input  logic                      i_mispredicted,
    input  logic [lhbp_pkg::XLEN-1:0] i_prediction_count,
    input  logic [lhbp_pkg::XLEN-1:0] i_mispredict_count,
    input  logic [lhbp_pkg::XLEN-1:0] i_btb_miss_count,

    output int                        o_fail_count,
    output int                        o_pending
);
    import lhbp_pkg::*;

    localparam int BTB_IDX_W    = $clog2(BTB_ENTRIES);
    localparam int HIST_IDX_W   = $clog2(HISTORY_ENTRIES);
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic            btb_hit;
        logic [XLEN-1:0] target;
        logic            taken;
        logic            mispredicted;
        logic [XLEN-1:0] update_total;
        logic [XLEN-1:0] mispredict_total;
        logic [XLEN-1:0] btb_miss_total;
    } t_branch_result;

    t_btb_entry              btb_mirror     [BTB_ENTRIES];
    logic [HISTORY_BITS-1:0] history_mirror [HISTORY_ENTRIES];
    logic [CNT_W-1:0]        counter_mirror [PATTERN_ENTRIES];
    logic [XLEN-1:0]         updates_seen;
    logic [XLEN-1:0]         mispredicts_seen;
    logic [XLEN-1:0]         btb_misses_seen;

    t_branch_result          expected_results [$];
    t_branch_result          observed;
    t_branch_result          oldest;
    int                      mismatches;
    int                      idx;

    function automatic logic [XLEN-1:0] bump(input logic [XLEN-1:0] value);
        return (value == '1) ? value : value + XLEN'(1);
    endfunction

    // Look up and, for an update, train the mirrored tables exactly once per transaction.
    function automatic t_branch_result resolve_branch(
        input logic            kind,
        input logic [XLEN-1:0] addr,
        input logic [XLEN-1:0] actual,
        input logic [XLEN-1:0] fall_through,
        input logic [XLEN-1:0] guessed
    );
        int                      btb_idx;
        int                      hist_idx;
        int                      pattern_idx;
        logic [HISTORY_BITS-1:0] hist;
        logic [TAG_W-1:0]        addr_tag;
        logic                    hit;
        logic                    went;
        t_branch_result          res;

        btb_idx     = int'(addr[2 +: BTB_IDX_W]);
        hist_idx    = int'(addr[2 +: HIST_IDX_W]);
        hist        = history_mirror[hist_idx];
        pattern_idx = int'(hist) & (PATTERN_ENTRIES - 1);
        addr_tag    = addr[XLEN-1:TAG_SHIFT];
        hit         = btb_mirror[btb_idx].valid && (btb_mirror[btb_idx].tag == addr_tag);
        res         = '0;

        if (kind == OP_PREDICT) begin
            res.btb_hit = hit;
            res.target  = hit ? btb_mirror[btb_idx].target : '0;
            res.taken   = (counter_mirror[pattern_idx] >= CNT_TAKEN);
        end else begin
            went             = (actual != fall_through);
            res.mispredicted = (actual != guessed);
            updates_seen     = bump(updates_seen);
            if (res.mispredicted)
                mispredicts_seen = bump(mispredicts_seen);
            if (went) begin
                if (!hit)
                    btb_misses_seen = bump(btb_misses_seen);
                btb_mirror[btb_idx].valid  = 1'b1;
                btb_mirror[btb_idx].tag    = addr_tag;
                btb_mirror[btb_idx].target = actual;
            end
            if (went && counter_mirror[pattern_idx] != CNT_MAX)
                counter_mirror[pattern_idx] = counter_mirror[pattern_idx] + CNT_W'(1);
            if (!went && counter_mirror[pattern_idx] != CNT_MIN)
                counter_mirror[pattern_idx] = counter_mirror[pattern_idx] - CNT_W'(1);
            history_mirror[hist_idx] = {hist[HISTORY_BITS-2:0], went};
        end

        res.update_total     = updates_seen;
        res.mispredict_total = mispredicts_seen;
        res.btb_miss_total   = btb_misses_seen;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (idx = 0; idx < BTB_ENTRIES; idx++)
                btb_mirror[idx] = '0;
            for (idx = 0; idx < HISTORY_ENTRIES; idx++)
                history_mirror[idx] = '0;
            for (idx = 0; idx < PATTERN_ENTRIES; idx++)
                counter_mirror[idx] = CNT_MIN;
            updates_seen     = '0;
            mispredicts_seen = '0;
            btb_misses_seen  = '0;
            mismatches       = 0;
            expected_results.delete();
        end else begin
            // Check the result side first: a result can never belong to a transaction
            // accepted at the same edge.
            if (i_out_valid && !i_out_stall) begin
                observed.btb_hit          = i_btb_hit;
                observed.target           = i_target;
                observed.taken            = i_taken;
                observed.mispredicted     = i_mispredicted;
                observed.update_total     = i_prediction_count;
                observed.mispredict_total = i_mispredict_count;
                observed.btb_miss_total   = i_btb_miss_count;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result with nothing outstanding: hit=%b target=%h",
                                 $realtime, observed.btb_hit, observed.target);
                end else begin
                    oldest = expected_results.pop_front();
                    if (observed.btb_hit !== oldest.btb_hit
                            || observed.target !== oldest.target
                            || observed.taken !== oldest.taken
                            || observed.mispredicted !== oldest.mispredicted
                            || observed.update_total !== oldest.update_total
                            || observed.mispredict_total !== oldest.mispredict_total
                            || observed.btb_miss_total !== oldest.btb_miss_total) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: exp hit=%b tgt=%h tk=%b mis=%b cnt=%0d/%0d/%0d",
                                     $realtime, oldest.btb_hit, oldest.target, oldest.taken,
                                     oldest.mispredicted, oldest.update_total,
                                     oldest.mispredict_total, oldest.btb_miss_total);
                            $display("%0t: act hit=%b tgt=%h tk=%b mis=%b cnt=%0d/%0d/%0d",
                                     $realtime, observed.btb_hit, observed.target,
                                     observed.taken, observed.mispredicted,
                                     observed.update_total, observed.mispredict_total,
                                     observed.btb_miss_total);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(resolve_branch(i_op, i_pc, i_actual_next_pc,
                                                          i_sequential_next_pc,
                                                          i_predicted_next_pc));
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
    end

endmodule

/* tb/tb.sv */
// Top level testbench: stimulus, flow control and verdict for the local history branch predictor.
`timescale 1ns / 1ps

module tb;

    import lhbp_pkg::*;

    localparam int BTB_ENTRIES     = 512;
    localparam int HISTORY_ENTRIES = 1024;
    localparam int HISTORY_BITS    = 10;
    localparam int PATTERN_ENTRIES = 1024;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 5;
    localparam int POOL_SIZE    = 24;
    // Long receiver hold-off: far longer than the three-stage pipeline, so the
    // block fills up and must raise its input stall.
    localparam int HOLD_CYCLES  = 80;
    // Trailing cycles after the last result.
    localparam int TAIL_CYCLES  = 12;

    logic            clk   = 1'b0;
    logic            rst_n = 1'b0;

    logic            in_valid           = 1'b0;
    logic            in_stall;
    logic            op                 = OP_PREDICT;
    logic [XLEN-1:0] pc                 = '0;
    logic [XLEN-1:0] actual_next_pc     = '0;
    logic [XLEN-1:0] sequential_next_pc = '0;
    logic [XLEN-1:0] predicted_next_pc  = '0;

    logic            out_valid;
    logic            out_stall = 1'b0;
    logic            btb_hit;
    logic [XLEN-1:0] target;
    logic            taken;
    logic            mispredicted;
    logic [XLEN-1:0] prediction_count;
    logic [XLEN-1:0] mispredict_count;
    logic [XLEN-1:0] btb_miss_count;

    int              fail_count;
    int              pending;

    // Idle rates in percent; the receive rate and the hold request cross into
    // the receiver process, so they are written with nonblocking assignments.
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    logic            hold_req      = 1'b0;
    logic            hold_seen     = 1'b0;
    int              hold_left     = 0;

    logic [XLEN-1:0] branch_pool [POOL_SIZE];

    always begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    local_history_branch_predictor #(
        .BTB_ENTRIES     (BTB_ENTRIES),
        .HISTORY_ENTRIES (HISTORY_ENTRIES),
        .HISTORY_BITS    (HISTORY_BITS),
        .PATTERN_ENTRIES (PATTERN_ENTRIES)
    ) u_dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_stall           (in_stall),
        .i_op                 (op),
        .i_pc                 (pc),
        .i_actual_next_pc     (actual_next_pc),
        .i_sequential_next_pc (sequential_next_pc),
        .i_predicted_next_pc  (predicted_next_pc),
        .o_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .o_btb_hit            (btb_hit),
        .o_target             (target),
        .o_taken              (taken),
        .o_mispredicted       (mispredicted),
        .o_prediction_count   (prediction_count),
        .o_mispredict_count   (mispredict_count),
        .o_btb_miss_count     (btb_miss_count)
    );

    lhbp_checker #(
        .BTB_ENTRIES     (BTB_ENTRIES),
        .HISTORY_ENTRIES (HISTORY_ENTRIES),
        .HISTORY_BITS    (HISTORY_BITS),
        .PATTERN_ENTRIES (PATTERN_ENTRIES)
    ) u_checker (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .i_in_stall           (in_stall),
        .i_op                 (op),
        .i_pc                 (pc),
        .i_actual_next_pc     (actual_next_pc),
        .i_sequential_next_pc (sequential_next_pc),
        .i_predicted_next_pc  (predicted_next_pc),
        .i_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .i_btb_hit            (btb_hit),
        .i_target             (target),
        .i_taken              (taken),
        .i_mispredicted       (mispredicted),
        .i_prediction_count   (prediction_count),
        .i_mispredict_count   (mispredict_count),
        .i_btb_miss_count     (btb_miss_count),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    // Receiver: stall at random, or hold off for a long stretch whenever the
    // stimulus toggles the hold request.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_seen <= 1'b0;
            hold_left <= 0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Offer one transaction, with random idle cycles ahead of it, and return at
    // the edge that accepts it. Valid stays high into the next call when no gap
    // is drawn, so it is never dropped and raised within one time step.
    task automatic send_item(
        input logic            kind,
        input logic [XLEN-1:0] addr,
        input logic [XLEN-1:0] actual,
        input logic [XLEN-1:0] fall_through,
        input logic [XLEN-1:0] guessed
    );
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid           <= 1'b1;
        op                 <= kind;
        pc                 <= addr;
        actual_next_pc     <= actual;
        sequential_next_pc <= fall_through;
        predicted_next_pc  <= guessed;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    // Stop offering and wait until every outstanding result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Random traffic, mostly predict/update pairs on a small set of branches so
    // that histories fill and counters saturate; the rest single transactions
    // and fully random noise.
    task automatic run_phase(
        input int          n_items,
        input int unsigned s_idle,
        input int unsigned r_idle,
        input bit          with_hold
    );
        int              count;
        int              slot;
        int              roll;
        logic            goes;
        logic [XLEN-1:0] addr;
        logic [XLEN-1:0] fall;
        logic [XLEN-1:0] dest;
        logic [XLEN-1:0] guess;

        send_idle_pct = s_idle;
        recv_idle_pct <= r_idle;
        if (with_hold)
            hold_req <= ~hold_req;
        count = 0;
        while (count < n_items) begin
            slot = $urandom_range(POOL_SIZE - 1);
            addr = branch_pool[slot];
            fall = ($urandom_range(9) == 0) ? $urandom : addr + 32'd4;
            // Bias even branches toward taken and odd ones toward not taken.
            goes = ($urandom_range(99) < ((slot % 2 == 0) ? 85 : 20));
            if (goes)
                dest = ($urandom_range(3) == 0) ? $urandom
                                                : branch_pool[(slot + 1) % POOL_SIZE];
            else
                dest = fall;
            case ($urandom_range(2))
                0:       guess = fall;
                1:       guess = dest;
                default: guess = $urandom;
            endcase
            roll = $urandom_range(99);
            if (roll < 70) begin
                send_item(OP_PREDICT, addr, $urandom, $urandom, $urandom);
                send_item(OP_UPDATE, addr, dest, fall, guess);
                count += 2;
            end else if (roll < 85) begin
                send_item(logic'($urandom_range(1)), addr, dest, fall, guess);
                count++;
            end else begin
                send_item(logic'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
                count++;
            end
        end
    endtask

    initial begin
        int i;

        // Build the branch set; every third address shares its BTB set with the
        // one before it under a different tag, to force evictions.
        for (i = 0; i < POOL_SIZE; i++) begin
            if (i % 3 == 2)
                branch_pool[i] = branch_pool[i - 1]
                               ^ ($urandom_range(1, 2**TAG_W - 1) << TAG_SHIFT);
            else
                branch_pool[i] = $urandom;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed transactions; the first one waits out the clearing pass.
        send_idle_pct = 26;
        recv_idle_pct <= 46;
        // Cold lookups at both address extremes.
        send_item(OP_PREDICT, '0, '0, '0, '0);
        send_item(OP_PREDICT, '1, '1, '1, '1);
        // Taken, mispredicted, BTB miss with all-ones fields; then hit on it.
        send_item(OP_UPDATE, '1, '1, '0, '0);
        send_item(OP_PREDICT, '1, '0, '0, '0);
        // Not taken and correctly predicted: BTB untouched, no miss counted.
        send_item(OP_UPDATE, '0, 32'h4, 32'h4, 32'h4);
        // Taken and predicted: fill; then taken on a hit with a new target.
        send_item(OP_UPDATE, '0, 32'h1000, 32'h4, 32'h1000);
        send_item(OP_UPDATE, '0, 32'h2000, 32'h4, 32'h1000);
        send_item(OP_PREDICT, '0, '0, '0, '0);
        // Same BTB set, other tag: miss, replace, and the old branch is gone.
        send_item(OP_PREDICT, 32'h800, '0, '0, '0);
        send_item(OP_UPDATE, 32'h800, 32'h3000, 32'h804, 32'h804);
        send_item(OP_PREDICT, '0, '0, '0, '0);
        // Fill one history with ones and train the counter it selects up to taken.
        for (i = 0; i < 12; i++)
            send_item(OP_UPDATE, 32'h40, 32'h100, 32'h44, 32'h100);
        send_item(OP_PREDICT, 32'h40, '0, '0, '0);
        // Not taken afterwards: counter steps down, mispredicted.
        send_item(OP_UPDATE, 32'h40, 32'h44, 32'h44, 32'h100);
        drain();

        // Sender lighter than receiver, then the other way round, then no
        // idling at all with a long receiver hold-off at its start.
        run_phase(433, 26, 46, 1'b0);
        drain();
        run_phase(433, 46, 26, 1'b0);
        drain();
        run_phase(434, 0, 0, 1'b1);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: the slowest correct run needs well under a tenth of this.
    initial begin
        #(2_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
